### rtl/core/ppc_pkg.sv
package ppc_pkg;

	localparam int COORD_W = 32;
	localparam int ICON_W = 5;
	localparam int CNT_W = 16;
	localparam int RIDX_W = 7;
	localparam int TOTAL_W = 32;

	// action codes on the input item
	localparam logic [1:0] ACT_ADD = 2'd0;
	localparam logic [1:0] ACT_CLEAR = 2'd1;
	localparam logic [1:0] ACT_READ = 2'd2;

	// decoded command ops
	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;
	localparam logic [1:0] OP_NOP = 2'd3;

	// config register indexes
	localparam logic [1:0] REG_CAM_X = 2'd0;
	localparam logic [1:0] REG_CAM_Y = 2'd1;
	localparam logic [1:0] REG_CAM_Z = 2'd2;

	typedef struct packed {
		logic [1:0] action;
		logic [ICON_W-1:0] icon_id;
		logic signed [COORD_W-1:0] pin_x;
		logic signed [COORD_W-1:0] pin_y;
		logic signed [COORD_W-1:0] pin_z;
		logic [CNT_W-1:0] pin_count;
		logic [RIDX_W-1:0] read_index;
	} item_t;

	typedef struct packed {
		logic [RIDX_W-1:0] bin_index;
		logic merged;
		logic table_full;
		logic bin_valid;
		logic signed [COORD_W-1:0] bin_x;
		logic signed [COORD_W-1:0] bin_y;
		logic signed [COORD_W-1:0] bin_z;
		logic [ICON_W-1:0] bin_icon;
		logic [TOTAL_W-1:0] bin_total;
		logic [CNT_W-1:0] bin_members;
	} result_t;

	// classified command between front and back
	typedef struct packed {
		logic [1:0] op;
		logic [ICON_W-1:0] icon;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		logic [CNT_W-1:0] cnt;
		logic [RIDX_W-1:0] ri;
	} cmd_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} cam_t;

	// one stored bin
	typedef struct packed {
		logic [ICON_W-1:0] icon;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		logic [TOTAL_W-1:0] total;
		logic [CNT_W-1:0] members;
	} entry_t;

endpackage

### rtl/core/ppc_front.sv
module ppc_front import ppc_pkg::*; #(
	parameter int ICON_COUNT = 32
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input item_t item,
	output logic full,
	input logic cmd_take,
	output logic cmd_valid,
	output cmd_t cmd
);

	cmd_t ent_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	cmd_t dec;
	logic do_push, do_pop;

	always_comb begin
		dec.icon = item.icon_id;
		dec.x = item.pin_x;
		dec.y = item.pin_y;
		dec.z = item.pin_z;
		dec.cnt = (item.pin_count == '0) ? CNT_W'(1) : item.pin_count;
		dec.ri = item.read_index;
		priority if (item.action == ACT_ADD && int'(item.icon_id) < ICON_COUNT)
			dec.op = OP_ADD;
		else if (item.action == ACT_CLEAR)
			dec.op = OP_CLEAR;
		else if (item.action == ACT_READ)
			dec.op = OP_READ;
		else
			dec.op = OP_NOP;
	end

	assign full = (count_q == 2'd2);
	assign cmd_valid = (count_q != 2'd0);
	assign cmd = ent_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = cmd_take && cmd_valid;

	always_ff @(posedge clk) begin
		if (do_push) ent_q[wr_ptr_q] <= dec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + 2'(do_push) - 2'(do_pop);
		end
	end

endmodule

### rtl/core/ppc_div.sv
module ppc_div import ppc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [COORD_W-1:0] old_val,
	input logic [CNT_W-1:0] n,
	input logic signed [COORD_W-1:0] pin_val,
	output logic done,
	output logic signed [COORD_W-1:0] quot
);

	// |old*n + pin| < 2^48, plus half the divisor
	localparam int MW = 49;
	localparam int DW = CNT_W + 1;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_MUL = 2'd1;
	localparam logic [1:0] PH_PREP = 2'd2;
	localparam logic [1:0] PH_RUN = 2'd3;

	logic [1:0] ph_q;
	logic signed [COORD_W-1:0] old_q, pin_q;
	logic [DW-1:0] d_q;
	logic [CNT_W-1:0] n_q;
	logic signed [MW-1:0] prod_q;
	logic signed [MW-1:0] sum;
	logic [MW-1:0] mag;
	logic [MW-1:0] dvd_q;
	logic [DW-1:0] rem_q;
	logic [DW:0] trial;
	logic qbit;
	logic neg_q, done_q;
	logic [5:0] cnt_q;
	logic [COORD_W-1:0] qlow;

	assign sum = prod_q + MW'(pin_q);
	assign mag = sum[MW-1] ? MW'(-sum) : MW'(sum);
	assign trial = {rem_q, dvd_q[MW-1]};
	assign qbit = (trial >= {1'b0, d_q});
	assign qlow = dvd_q[COORD_W-1:0];
	assign quot = neg_q ? -qlow : qlow;
	assign done = done_q;

	always_ff @(posedge clk) begin
		unique case (ph_q)
			PH_IDLE: if (start) begin
				old_q <= old_val;
				pin_q <= pin_val;
				n_q <= n;
				d_q <= DW'(n) + DW'(1);
			end
			PH_MUL: prod_q <= MW'(old_q * $signed({1'b0, n_q}));
			PH_PREP: begin
				neg_q <= sum[MW-1];
				dvd_q <= mag + MW'(d_q >> 1);
				rem_q <= '0;
			end
			PH_RUN: begin
				rem_q <= qbit ? DW'(trial - {1'b0, d_q}) : DW'(trial);
				dvd_q <= {dvd_q[MW-2:0], qbit};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_IDLE;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (ph_q == PH_RUN) && (cnt_q == 6'd1);
			unique case (ph_q)
				PH_IDLE: if (start) ph_q <= PH_MUL;
				PH_MUL: ph_q <= PH_PREP;
				PH_PREP: begin
					ph_q <= PH_RUN;
					cnt_q <= 6'(MW);
				end
				PH_RUN: begin
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd1) ph_q <= PH_IDLE;
				end
				default: ph_q <= PH_IDLE;
			endcase
		end
	end

endmodule

### rtl/core/ppc_back.sv
module ppc_back import ppc_pkg::*; #(
	parameter int BIN_COUNT = 128
) (
	input logic clk,
	input logic arst_n,
	input cam_t cam,
	input logic cmd_valid,
	input cmd_t cmd,
	output logic cmd_take,
	output logic res_valid,
	output result_t res,
	input logic res_rdy
);

	localparam int AW = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
	localparam int MAG_W = COORD_W + 1;
	localparam int SQ_W = 2 * MAG_W;
	localparam int SUM_W = SQ_W + 2;
	localparam int CMP_W = SUM_W + 4;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_READ = 3'd2;
	localparam logic [2:0] ST_DIV = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0] state_q;
	cmd_t cmd_q;
	result_t res_q;
	logic [AW:0] used_q, scan_q;

	entry_t mem_q [BIN_COUNT];
	logic mem_we;
	logic [AW-1:0] waddr, raddr;
	entry_t wdata;
	entry_t rd_s1;

	// scan pipeline
	logic issue;
	logic v_s1, v_s2, v_s3, v_s4;
	logic [AW-1:0] idx_s1, idx_s2, idx_s3, idx_s4;
	entry_t ent_s2, ent_s3, ent_s4;
	logic ok_s2, ok_s3, ok_s4;
	logic [MAG_W-1:0] dp_s2 [3];
	logic [MAG_W-1:0] dc_s2 [3];
	logic [SQ_W-1:0] dp_s3 [3];
	logic [SQ_W-1:0] dc_s3 [3];
	logic [CMP_W-1:0] dp_s4;
	logic [SUM_W-1:0] dc_s4;
	logic hit, drained;

	// merge
	entry_t mt_q;
	logic [AW-1:0] mi_q;
	logic [2:0] div_done;
	logic signed [COORD_W-1:0] mean [3];
	logic [TOTAL_W:0] tsum;
	entry_t merged_e, new_e;

	logic ri_ok;

	function automatic logic [MAG_W-1:0] absdiff(logic signed [COORD_W-1:0] a,
		logic signed [COORD_W-1:0] b);
		logic signed [MAG_W-1:0] d;
		d = MAG_W'(a) - MAG_W'(b);
		return d[MAG_W-1] ? MAG_W'(-d) : MAG_W'(d);
	endfunction

	function automatic result_t from_entry(entry_t e, logic [AW-1:0] idx, logic mrg);
		result_t r;
		r.bin_index = RIDX_W'(idx);
		r.merged = mrg;
		r.table_full = 1'b0;
		r.bin_valid = 1'b1;
		r.bin_x = e.x;
		r.bin_y = e.y;
		r.bin_z = e.z;
		r.bin_icon = e.icon;
		r.bin_total = e.total;
		r.bin_members = e.members;
		return r;
	endfunction

	assign cmd_take = (state_q == ST_IDLE) && cmd_valid;
	assign res_valid = (state_q == ST_EMIT);
	assign res = res_q;
	assign ri_ok = ({25'b0, cmd.ri} < 32'(used_q)) && (int'(cmd.ri) < BIN_COUNT);

	assign issue = (state_q == ST_SCAN) && (scan_q < used_q) && !hit;
	assign hit = v_s4 && ok_s4 && (dp_s4 <= CMP_W'(dc_s4));
	assign drained = !issue && !v_s1 && !v_s2 && !v_s3 && !v_s4;

	always_comb begin
		if (state_q == ST_IDLE) raddr = AW'(cmd.ri);
		else raddr = scan_q[AW-1:0];
	end

	// new bin at the end of the table
	always_comb begin
		new_e.icon = cmd_q.icon;
		new_e.x = cmd_q.x;
		new_e.y = cmd_q.y;
		new_e.z = cmd_q.z;
		new_e.total = TOTAL_W'(cmd_q.cnt);
		new_e.members = CNT_W'(1);
	end

	always_comb begin
		tsum = (TOTAL_W + 1)'(mt_q.total) + (TOTAL_W + 1)'(cmd_q.cnt);
		merged_e.icon = mt_q.icon;
		merged_e.x = mean[0];
		merged_e.y = mean[1];
		merged_e.z = mean[2];
		merged_e.total = tsum[TOTAL_W] ? '1 : tsum[TOTAL_W-1:0];
		merged_e.members = (mt_q.members == '1) ? mt_q.members : mt_q.members + CNT_W'(1);
	end

	always_comb begin
		mem_we = 1'b0;
		waddr = mi_q;
		wdata = merged_e;
		if (state_q == ST_DIV && div_done[0]) begin
			mem_we = 1'b1;
		end else if (state_q == ST_SCAN && drained && used_q < (AW + 1)'(BIN_COUNT)) begin
			mem_we = 1'b1;
			waddr = used_q[AW-1:0];
			wdata = new_e;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem_q[waddr] <= wdata;
		rd_s1 <= mem_q[raddr];
	end

	// distance pipeline payload
	always_ff @(posedge clk) begin
		idx_s1 <= scan_q[AW-1:0];
		idx_s2 <= idx_s1;
		ent_s2 <= rd_s1;
		ok_s2 <= (rd_s1.icon == cmd_q.icon);
		dp_s2[0] <= absdiff(cmd_q.x, rd_s1.x);
		dp_s2[1] <= absdiff(cmd_q.y, rd_s1.y);
		dp_s2[2] <= absdiff(cmd_q.z, rd_s1.z);
		dc_s2[0] <= absdiff(rd_s1.x, cam.x);
		dc_s2[1] <= absdiff(rd_s1.y, cam.y);
		dc_s2[2] <= absdiff(rd_s1.z, cam.z);
		idx_s3 <= idx_s2;
		ent_s3 <= ent_s2;
		ok_s3 <= ok_s2;
		for (int i = 0; i < 3; i++) begin
			dp_s3[i] <= {{MAG_W{1'b0}}, dp_s2[i]} * {{MAG_W{1'b0}}, dp_s2[i]};
			dc_s3[i] <= {{MAG_W{1'b0}}, dc_s2[i]} * {{MAG_W{1'b0}}, dc_s2[i]};
		end
		idx_s4 <= idx_s3;
		ent_s4 <= ent_s3;
		ok_s4 <= ok_s3;
		dp_s4 <= CMP_W'(SUM_W'(dp_s3[0]) + SUM_W'(dp_s3[1]) + SUM_W'(dp_s3[2])) << 4;
		dc_s4 <= SUM_W'(dc_s3[0]) + SUM_W'(dc_s3[1]) + SUM_W'(dc_s3[2]);
		if (hit) begin
			mt_q <= ent_s4;
			mi_q <= idx_s4;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: if (cmd_valid) begin
				cmd_q <= cmd;
				// read echoes its index; everything else starts from zero
				res_q <= (cmd.op == OP_READ) ?
					result_t'({cmd.ri, {($bits(result_t) - RIDX_W){1'b0}}}) : '0;
			end
			ST_SCAN: if (drained) begin
				if (used_q < (AW + 1)'(BIN_COUNT)) res_q <= from_entry(new_e, used_q[AW-1:0], 1'b0);
				else res_q.table_full <= 1'b1;
			end
			ST_READ: res_q <= from_entry(rd_s1, AW'(cmd_q.ri), 1'b0);
			ST_DIV: if (div_done[0]) res_q <= from_entry(merged_e, mi_q, 1'b1);
			ST_EMIT: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			used_q <= '0;
			scan_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1 && !hit;
			v_s3 <= v_s2 && !hit;
			v_s4 <= v_s3 && !hit;
			if (issue) scan_q <= scan_q + 1'b1;
			unique case (state_q)
				ST_IDLE: if (cmd_valid) begin
					scan_q <= '0;
					unique case (cmd.op)
						OP_ADD: state_q <= ST_SCAN;
						OP_CLEAR: begin
							used_q <= '0;
							state_q <= ST_EMIT;
						end
						OP_READ: state_q <= ri_ok ? ST_READ : ST_EMIT;
						OP_NOP: state_q <= ST_EMIT;
						default: state_q <= ST_EMIT;
					endcase
				end
				ST_SCAN: begin
					if (hit) state_q <= ST_DIV;
					else if (drained) begin
						if (used_q < (AW + 1)'(BIN_COUNT)) used_q <= used_q + 1'b1;
						state_q <= ST_EMIT;
					end
				end
				ST_READ: state_q <= ST_EMIT;
				ST_DIV: if (div_done[0]) state_q <= ST_EMIT;
				ST_EMIT: if (res_rdy) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	ppc_div u_div_x (
		.clk(clk), .arst_n(arst_n), .start(hit),
		.old_val(ent_s4.x), .n(ent_s4.members), .pin_val(cmd_q.x),
		.done(div_done[0]), .quot(mean[0])
	);
	ppc_div u_div_y (
		.clk(clk), .arst_n(arst_n), .start(hit),
		.old_val(ent_s4.y), .n(ent_s4.members), .pin_val(cmd_q.y),
		.done(div_done[1]), .quot(mean[1])
	);
	ppc_div u_div_z (
		.clk(clk), .arst_n(arst_n), .start(hit),
		.old_val(ent_s4.z), .n(ent_s4.members), .pin_val(cmd_q.z),
		.done(div_done[2]), .quot(mean[2])
	);

`ifndef SYNTHESIS
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= (AW + 1)'(BIN_COUNT))
		else $error("bin count past table size");
	a_we_state: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_SCAN || state_q == ST_DIV))
		else $error("table write outside scan or merge");
	a_div_lanes: assert property (@(posedge clk) disable iff (!arst_n)
		div_done[0] |-> (div_done[1] && div_done[2] && state_q == ST_DIV))
		else $error("mean lanes out of step");
	a_emit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && !res_rdy) |=> (state_q == ST_EMIT && $stable(res_q)))
		else $error("result dropped while stalled");
`endif

endmodule

### rtl/core/proximity_pin_clusterer.sv
// Add: the bin scan, then a merge through the mean divider (1 bit/cycle) or an appended bin;
//   a valid read fetches one bin, clear and ignored items go straight out; all pass the result register.
// Throughput: one item at a time in the back end; set by the bin scan (one table read per
//   cycle until a match) and the bit-serial mean divider.
// Reset (arst_n low, async): bin table empty, queues empty, camera registers zero.
module proximity_pin_clusterer import ppc_pkg::*; #(
	parameter int BIN_COUNT = 128,
	parameter int ICON_COUNT = 32
) (
	input logic clk,
	input logic arst_n,
	// item queue side
	input logic push,
	output logic full,
	input item_t item,
	// result queue side
	output logic empty,
	input logic pop,
	output result_t result,
	// camera config
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [COORD_W-1:0] cfg_data
);

	cam_t cam_q;
	logic cmd_valid, cmd_take;
	cmd_t cmd;
	logic res_valid, res_rdy;
	result_t res;
	result_t out_q;
	logic out_valid_q;

	// camera registers; writes past the last index are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CAM_X: cam_q.x <= cfg_data;
				REG_CAM_Y: cam_q.y <= cfg_data;
				REG_CAM_Z: cam_q.z <= cfg_data;
				default: ;
			endcase
		end
	end

	// front: decode and buffer incoming transfers
	ppc_front #(.ICON_COUNT(ICON_COUNT)) u_front (
		.clk(clk), .arst_n(arst_n),
		.push(push), .item(item), .full(full),
		.cmd_take(cmd_take), .cmd_valid(cmd_valid), .cmd(cmd)
	);

	// back: scan, merge, append, read, clear
	ppc_back #(.BIN_COUNT(BIN_COUNT)) u_back (
		.clk(clk), .arst_n(arst_n), .cam(cam_q),
		.cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take),
		.res_valid(res_valid), .res(res), .res_rdy(res_rdy)
	);

	// single-entry result register; refills in the cycle it is popped
	assign res_rdy = !out_valid_q || pop;
	assign empty = !out_valid_q;
	assign result = out_q;

	always_ff @(posedge clk) begin
		if (res_valid && res_rdy) out_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_rdy) begin
			out_valid_q <= res_valid;
		end
	end

endmodule

### tb/proximity_pin_clusterer_tb.sv
module proximity_pin_clusterer_tb;
	import ppc_pkg::*;

	localparam int NBINS = 128;
	localparam int NPHASE = 8;
	localparam int PHASE_ITEMS = 200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	item_t item = '0;
	logic empty;
	logic pop = 1'b0;
	result_t result;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = REG_CAM_X;
	logic [COORD_W-1:0] cfg_data = '0;

	always #5 clk = ~clk;

	proximity_pin_clusterer u_top (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .result(result),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// ---------------------------------------------------------------
	// Shadow of the bin table and camera, advanced as items are queued.
	// Camera writes only happen while the DUT is drained, so computing
	// expectations at generation time is safe.
	// ---------------------------------------------------------------
	longint cam_x = 0, cam_y = 0, cam_z = 0;
	int unsigned used_bins = 0;
	logic [ICON_W-1:0] sh_icon [NBINS];
	longint sh_x [NBINS], sh_y [NBINS], sh_z [NBINS];
	longint unsigned sh_total [NBINS];
	int unsigned sh_members [NBINS];

	item_t pend_items [$];      // items waiting for the driver
	result_t bin_results [$];   // expected results, oldest first

	int errors = 0;
	int n_adds = 0, n_merges = 0, n_full = 0, n_reads = 0, n_clears = 0, n_checked = 0;
	bit quiet = 0;              // no idling in the closing phase

	// squared euclidean distance, exact (each term below 2^66)
	function automatic logic [71:0] sq_dist(longint ax, longint ay, longint az,
			longint bx, longint by, longint bz);
		longint d [3];
		logic [71:0] m;
		logic [71:0] acc;
		d[0] = ax - bx; d[1] = ay - by; d[2] = az - bz;
		acc = '0;
		for (int i = 0; i < 3; i++) begin
			m = (d[i] < 0) ? 72'(-d[i]) : 72'(d[i]);
			acc += m * m;
		end
		return acc;
	endfunction

	// running mean, rounded to nearest, ties away from zero
	function automatic longint run_mean(longint old, int unsigned n, longint p);
		longint sum;
		longint unsigned mag, div, q;
		sum = old * longint'(n) + p;
		div = longint'(n) + 1;
		mag = (sum < 0) ? longint'(-sum) : sum;
		q = (mag + div / 2) / div;
		return (sum < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic void fill_bin(ref result_t r, input int b);
		r.bin_valid = 1'b1;
		r.bin_x = sh_x[b][31:0];
		r.bin_y = sh_y[b][31:0];
		r.bin_z = sh_z[b][31:0];
		r.bin_icon = sh_icon[b];
		r.bin_total = sh_total[b][31:0];
		r.bin_members = sh_members[b][15:0];
	endfunction

	function automatic result_t cluster_step(item_t it);
		result_t r;
		longint px, py, pz;
		longint unsigned cnt;
		logic [71:0] dp, dc;
		int b;
		r = '0;
		px = longint'(it.pin_x); py = longint'(it.pin_y); pz = longint'(it.pin_z);
		cnt = (it.pin_count == 0) ? 1 : it.pin_count;
		case (it.action)
			ACT_CLEAR: begin
				used_bins = 0;
				n_clears++;
			end
			ACT_READ: begin
				n_reads++;
				r.bin_index = it.read_index;
				if (it.read_index < used_bins) fill_bin(r, it.read_index);
			end
			ACT_ADD: begin
				n_adds++;
				for (b = 0; b < used_bins; b++) begin
					if (sh_icon[b] != it.icon_id) continue;
					dp = sq_dist(px, py, pz, sh_x[b], sh_y[b], sh_z[b]) << 4;
					dc = sq_dist(sh_x[b], sh_y[b], sh_z[b], cam_x, cam_y, cam_z);
					if (dp <= dc) break;
				end
				if (b < used_bins) begin
					sh_x[b] = run_mean(sh_x[b], sh_members[b], px);
					sh_y[b] = run_mean(sh_y[b], sh_members[b], py);
					sh_z[b] = run_mean(sh_z[b], sh_members[b], pz);
					sh_total[b] = sh_total[b] + cnt;
					if (sh_total[b] > 64'hFFFF_FFFF) sh_total[b] = 64'hFFFF_FFFF;
					if (sh_members[b] < 16'hFFFF) sh_members[b]++;
					r.bin_index = b[6:0];
					r.merged = 1'b1;
					fill_bin(r, b);
					n_merges++;
				end else if (used_bins < NBINS) begin
					b = used_bins++;
					sh_icon[b] = it.icon_id;
					sh_x[b] = px; sh_y[b] = py; sh_z[b] = pz;
					sh_total[b] = cnt;
					sh_members[b] = 1;
					r.bin_index = b[6:0];
					fill_bin(r, b);
				end else begin
					r.table_full = 1'b1;
					n_full++;
				end
			end
			default: ;  // unused action: all zero
		endcase
		return r;
	endfunction

	function automatic void queue_item(item_t it);
		pend_items.push_back(it);
		bin_results.push_back(cluster_step(it));
	endfunction

	function automatic item_t mk_add(logic [4:0] icon, logic [31:0] x, logic [31:0] y,
			logic [31:0] z, logic [15:0] cnt);
		item_t it;
		it = '0;
		it.action = ACT_ADD; it.icon_id = icon;
		it.pin_x = x; it.pin_y = y; it.pin_z = z; it.pin_count = cnt;
		it.read_index = 7'($urandom_range(0, 127));
		return it;
	endfunction

	function automatic item_t mk_other(logic [1:0] act, logic [6:0] idx);
		item_t it;
		logic [127:0] rnd;
		rnd = {$urandom, $urandom, $urandom, $urandom};
		it = rnd[$bits(item_t)-1:0];
		it.action = act;
		it.read_index = idx;
		return it;
	endfunction

	// ---------------------------------------------------------------
	// Driver: offers the head of pend_items, with random idle bursts.
	// ---------------------------------------------------------------
	int push_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full)
				void'(pend_items.pop_front());
			if (push_gap > 0) begin
				push_gap <= push_gap - 1;
				push <= 1'b0;
			end else if ((push && !full ? pend_items.size() : pend_items.size()) > 0) begin
				push <= 1'b1;
				item <= pend_items[0];
				if (!quiet && $urandom_range(0, 19) == 0)
					push_gap <= $urandom_range(1, 11);
			end else begin
				push <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// Monitor: pops results with random stall bursts and checks each
	// transfer field by field against the oldest expectation.
	// ---------------------------------------------------------------
	int pop_gap = 0;
	task automatic cmp(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: mismatch %s expected %0h actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (bin_results.size() == 0) begin
					$display("%0t: unexpected result transfer, expected none actual %p",
						$time, result);
					errors++;
				end else begin
					want = bin_results.pop_front();
					n_checked++;
					cmp("bin_index", want.bin_index, result.bin_index);
					cmp("merged", want.merged, result.merged);
					cmp("table_full", want.table_full, result.table_full);
					cmp("bin_valid", want.bin_valid, result.bin_valid);
					cmp("bin_x", want.bin_x, result.bin_x);
					cmp("bin_y", want.bin_y, result.bin_y);
					cmp("bin_z", want.bin_z, result.bin_z);
					cmp("bin_icon", want.bin_icon, result.bin_icon);
					cmp("bin_total", want.bin_total, result.bin_total);
					cmp("bin_members", want.bin_members, result.bin_members);
				end
			end
			if (pop_gap > 0) begin
				pop_gap <= pop_gap - 1;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
				if (!quiet && $urandom_range(0, 19) == 0)
					pop_gap <= $urandom_range(1, 11);
			end
		end
	end

	// camera write; only called with the DUT drained
	task automatic write_cam(logic [1:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_CAM_X: cam_x = longint'(signed'(val));
			REG_CAM_Y: cam_y = longint'(signed'(val));
			default: cam_z = longint'(signed'(val));
		endcase
	endtask

	task automatic drain();
		while (pend_items.size() != 0 || bin_results.size() != 0)
			@(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	initial begin
		logic [31:0] cx [4], cy [4], cz [4];
		logic [4:0] cicon [4];
		logic [31:0] cam_set [3];
		int sel, k, guard;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: camera at origin (reset value), then every register's
		// extremes get exercised by the phases below
		queue_item(mk_add(5'd31, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF));
		queue_item(mk_add(5'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'd0));
		// exact same spot always joins: mean with extreme coordinates
		queue_item(mk_add(5'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'd1));
		queue_item(mk_add(5'd0, 32'h8000_0100, 32'h8000_0003, 32'h7FFF_FFFF, 16'hFFFF));
		// same spot, other icon: must open a new bin
		queue_item(mk_add(5'd1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h8000));
		queue_item(mk_add(5'd31, 32'h7FFF_FFF0, 32'h7FFF_FFFF, 32'h7FFF_FF00, 16'h0001));
		// neighbouring pins of both signs near the origin; with the camera there they stay in separate bins
		queue_item(mk_add(5'd7, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0000, 16'd3));
		queue_item(mk_add(5'd7, 32'hFFFF_FFFE, 32'h0000_0002, 32'h0000_0001, 16'd3));
		queue_item(mk_other(ACT_READ, 7'd0));
		queue_item(mk_other(ACT_READ, 7'd4));
		queue_item(mk_other(ACT_READ, 7'd5));
		queue_item(mk_other(ACT_READ, 7'd127));
		queue_item(mk_other(OP_NOP, 7'd0));
		queue_item(mk_other(ACT_CLEAR, 7'd0));
		queue_item(mk_other(ACT_READ, 7'd0));
		queue_item(mk_add(5'd3, 32'h0000_1234, 32'hFFFF_0000, 32'h0000_0000, 16'd9));
		queue_item(mk_other(ACT_READ, 7'd0));
		// fill the table, then overflow it
		guard = 0;
		while (used_bins < NBINS && guard < 1000) begin
			queue_item(mk_add(5'($urandom_range(0, 31)), $urandom, $urandom, $urandom,
				16'($urandom)));
			guard++;
		end
		for (k = 0; k < 4; k++)
			queue_item(mk_add(5'($urandom_range(0, 31)), $urandom, $urandom, $urandom,
				16'($urandom)));
		queue_item(mk_other(ACT_READ, 7'd127));
		drain();

		// random phases, each under its own camera
		for (int ph = 0; ph < NPHASE; ph++) begin
			if (ph == NPHASE - 1) quiet = 1;
			case (ph % 4)
				0: cam_set = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
				1: cam_set = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
				2: cam_set = '{32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF};
				default: cam_set = '{$urandom, $urandom, $urandom};
			endcase
			write_cam(REG_CAM_X, cam_set[0]);
			write_cam(REG_CAM_Y, cam_set[1]);
			write_cam(REG_CAM_Z, cam_set[2]);
			for (k = 0; k < 4; k++) begin
				cx[k] = $urandom; cy[k] = $urandom; cz[k] = $urandom;
				cicon[k] = 5'($urandom_range(0, 31));
			end
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				sel = $urandom_range(0, 99);
				if (sel < 55) begin
					// pins scattered around a cluster center: mostly joins
					k = $urandom_range(0, 3);
					queue_item(mk_add(cicon[k],
						cx[k] + ($urandom >> $urandom_range(4, 31)),
						cy[k] - ($urandom >> $urandom_range(4, 31)),
						cz[k] + ($urandom >> $urandom_range(4, 31)),
						16'($urandom)));
				end else if (sel < 78) begin
					queue_item(mk_add(5'($urandom_range(0, 31)), $urandom, $urandom, $urandom,
						16'($urandom)));
				end else if (sel < 95) begin
					queue_item(mk_other(ACT_READ, 7'($urandom_range(0, 127))));
				end else if (sel < 98) begin
					queue_item(mk_other(ACT_CLEAR, 7'($urandom_range(0, 127))));
				end else begin
					queue_item(mk_other(OP_NOP, 7'($urandom_range(0, 127))));
				end
			end
			drain();
		end

		repeat (300) @(posedge clk);
		$display("covered %0d adds (%0d joins, %0d table-full), %0d reads, %0d clears",
			n_adds, n_merges, n_full, n_reads, n_clears);
		$display("%0d results checked over %0d camera settings, %0d errors",
			n_checked, NPHASE + 1, errors);
		if (errors == 0 && bin_results.size() == 0)
			$display("[proximity_pin_clusterer] OK");
		else
			$display("[proximity_pin_clusterer] ERROR");
		$finish;
	end

	// watchdog
	initial begin
		#40000000;
		$display("[proximity_pin_clusterer] ERROR");
		$finish;
	end

endmodule
